[sv/nn_downscale_threshold_bitpack_macros.svh]
// Assertion macros shared by the downscale/binarize block.
// Expects clk and rst (synchronous, active high) in the using scope.
`ifndef NN_DOWNSCALE_THRESHOLD_BITPACK_MACROS_SVH
`define NN_DOWNSCALE_THRESHOLD_BITPACK_MACROS_SVH

// Same-cycle implication.
`define NNDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NNDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/nnds_pkg.sv]
// Package for the downscale/binarize/bit-pack block: sizes, widths, types.
// No dependencies.
package nnds_pkg;

  localparam int SRC_WIDTH     = 320;
  localparam int SRC_HEIGHT    = 240;
  localparam int OUT_WIDTH     = 128;
  localparam int OUT_HEIGHT    = 64;
  localparam int BYTES_PER_ROW = (OUT_WIDTH + 7) / 8;

  // field widths
  localparam int PIX_W    = 8;
  localparam int THR_W    = 8;
  localparam int ROFF_W   = 6;
  localparam int INDEX_W  = 10;

  // counter widths
  localparam int SRC_COL_W  = $clog2(SRC_WIDTH + 1);
  localparam int SRC_ROW_W  = $clog2(SRC_HEIGHT + 1);
  localparam int OUT_COL_W  = $clog2(OUT_WIDTH + 1);
  localparam int OUT_ROW_W  = $clog2(OUT_HEIGHT + 1);
  localparam int COL_HALF_W = $clog2(5 * OUT_WIDTH + 8);
  localparam int ROW_HALF_W = $clog2(2 * SRC_HEIGHT + 5 * (1 << ROFF_W) + 8);

  // register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_ROW_OFFSET = 1'b1;

  localparam logic [THR_W-1:0]  THRESHOLD_RST  = THR_W'(120);
  localparam logic [ROFF_W-1:0] ROW_OFFSET_RST = ROFF_W'(16);

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [ROFF_W-1:0] row_offset;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } item_t;

  typedef struct packed {
    logic [7:0]         bitmap_byte;
    logic [INDEX_W-1:0] byte_index;
    logic               last;
  } result_t;

endpackage

[sv/nnds_regs.sv]
// APB configuration registers: threshold and row offset.
// Depends on nnds_pkg.
module nnds_regs import nnds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // word select on paddr[2]; byte offset bits ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= THRESHOLD_RST;
      cfg.row_offset <= ROW_OFFSET_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_THRESHOLD:  cfg.threshold  <= pwdata[THR_W-1:0];
        REG_ROW_OFFSET: cfg.row_offset <= pwdata[ROFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD:  prdata = APB_DATA_W'(cfg.threshold);
      REG_ROW_OFFSET: prdata = APB_DATA_W'(cfg.row_offset);
      default:        prdata = '0;
    endcase
  end

endmodule

[sv/nnds_scan.sv]
// Raster counters, nearest-neighbor sample pick, threshold and bit packing.
// Depends on nnds_pkg.
module nnds_scan import nnds_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,   // registered word consumed this cycle
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    emit,
  output result_t result
);

  logic [SRC_COL_W-1:0]  src_col,       src_col_next;
  logic [SRC_ROW_W-1:0]  src_row,       src_row_next;
  logic [COL_HALF_W-1:0] next_col_half, next_col_half_next;
  logic [ROW_HALF_W-1:0] next_row_half, next_row_half_next;
  logic [OUT_COL_W-1:0]  out_col,       out_col_next;
  logic [OUT_ROW_W-1:0]  out_row,       out_row_next;
  logic [7:0]            pack_shift,    pack_shift_next;

  // effective state after an optional frame restart
  logic [SRC_COL_W-1:0]  e_src_col;
  logic [SRC_ROW_W-1:0]  e_src_row;
  logic [COL_HALF_W-1:0] e_col_half;
  logic [ROW_HALF_W-1:0] e_row_half;
  logic [OUT_COL_W-1:0]  e_out_col;
  logic [OUT_ROW_W-1:0]  e_out_row;
  logic [7:0]            e_pack;

  logic                  done, row_kept, take, pix_bit;
  logic [7:0]            pack_new;
  logic [OUT_COL_W-1:0]  col_new;
  logic [2:0]            filled;
  logic [SRC_COL_W-1:0]  src_col_inc;

  always_comb begin
    if (item.frame_start) begin
      e_src_col  = '0;
      e_src_row  = '0;
      e_col_half = '0;
      e_row_half = ROW_HALF_W'(cfg.row_offset) * ROW_HALF_W'(5);
      e_out_col  = '0;
      e_out_row  = '0;
      e_pack     = '0;
    end else begin
      e_src_col  = src_col;
      e_src_row  = src_row;
      e_col_half = next_col_half;
      e_row_half = next_row_half;
      e_out_col  = out_col;
      e_out_row  = out_row;
      e_pack     = pack_shift;
    end

    done     = (e_out_row >= OUT_ROW_W'(OUT_HEIGHT)) || (e_src_row >= SRC_ROW_W'(SRC_HEIGHT));
    row_kept = (ROW_HALF_W'(e_src_row) == (e_row_half >> 1));
    take     = !done && row_kept && (e_out_col < OUT_COL_W'(OUT_WIDTH))
               && (COL_HALF_W'(e_src_col) == (e_col_half >> 1));
    pix_bit  = (item.pixel >= cfg.threshold);

    pack_new = take ? {e_pack[6:0], pix_bit} : e_pack;
    col_new  = take ? e_out_col + OUT_COL_W'(1) : e_out_col;
    filled   = col_new[2:0];
    emit     = take && ((filled == 3'd0) || (col_new == OUT_COL_W'(OUT_WIDTH)));

    // left-align a short final byte: shift by (8 - filled) mod 8
    result.bitmap_byte = pack_new << (3'd0 - filled);
    result.byte_index  = INDEX_W'(e_out_row * BYTES_PER_ROW) + INDEX_W'(e_out_col >> 3);
    result.last        = (e_out_row == OUT_ROW_W'(OUT_HEIGHT - 1))
                         && (col_new == OUT_COL_W'(OUT_WIDTH));

    src_col_inc = e_src_col + SRC_COL_W'(1);

    src_col_next       = e_src_col;
    src_row_next       = e_src_row;
    next_col_half_next = e_col_half;
    next_row_half_next = e_row_half;
    out_col_next       = e_out_col;
    out_row_next       = e_out_row;
    pack_shift_next    = e_pack;

    if (!done) begin
      out_col_next       = col_new;
      next_col_half_next = take ? e_col_half + COL_HALF_W'(5) : e_col_half;
      pack_shift_next    = emit ? 8'd0 : pack_new;
      src_col_next       = src_col_inc;
      if (src_col_inc >= SRC_COL_W'(SRC_WIDTH)) begin
        // end of source line: partial bits dropped
        src_col_next       = '0;
        next_col_half_next = '0;
        out_col_next       = '0;
        pack_shift_next    = '0;
        src_row_next       = e_src_row + SRC_ROW_W'(1);
        if (row_kept) begin
          out_row_next       = e_out_row + OUT_ROW_W'(1);
          next_row_half_next = e_row_half + ROW_HALF_W'(5);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col       <= '0;
      src_row       <= '0;
      next_col_half <= '0;
      next_row_half <= ROW_HALF_W'(ROW_OFFSET_RST) * ROW_HALF_W'(5);
      out_col       <= '0;
      out_row       <= '0;
      pack_shift    <= '0;
    end else if (advance) begin
      src_col       <= src_col_next;
      src_row       <= src_row_next;
      next_col_half <= next_col_half_next;
      next_row_half <= next_row_half_next;
      out_col       <= out_col_next;
      out_row       <= out_row_next;
      pack_shift    <= pack_shift_next;
    end
  end

endmodule

[sv/nn_downscale_threshold_bitpack.sv]
// Top level: nearest-neighbor 2.5x downscale, threshold, MSB-first bit packing.
// Depends on nnds_pkg, nnds_regs, nnds_scan and the assertion macro header.
//
//  channel   dir  handshake                 payload
//  pixel     in   pix_valid / pix_ready     pixel[7:0], frame_start
//  byte      out  byte_valid / byte_ready   bitmap_byte[7:0], byte_index[9:0], last
//  config    in   APB psel/penable/pwrite   paddr[2:0], pwdata[31:0] -> prdata
//
// One pixel word per clock, sustained while the byte output is not stalled;
// byte_valid rises once the pixel that completes a byte has passed the input
// register and then the counter/threshold/pack logic into the output register.
// The single raster-counter update per cycle sets that rate.
// Reset (rst, synchronous) clears both pipeline valids and puts the counters at
// the start of a frame with the reset row offset; no clearing pass.
// A stalled byte output holds its register; the input register still takes a
// word while its slot frees in the same cycle the output is drained.
`include "nn_downscale_threshold_bitpack_macros.svh"

module nn_downscale_threshold_bitpack import nnds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // pixel word in
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  logic [PIX_W-1:0]      pixel,
  input  logic                  frame_start,
  // packed byte word out
  output logic                  byte_valid,
  input  logic                  byte_ready,
  output logic [7:0]            bitmap_byte,
  output logic [INDEX_W-1:0]    byte_index,
  output logic                  last
);

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  logic    emit;
  result_t result;
  result_t out_reg;

  nnds_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1 word moves on whenever the output register is free or draining.
  assign advance   = s1_valid && (!byte_valid || byte_ready);
  assign pix_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_ready) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      s1_item.pixel       <= pixel;
      s1_item.frame_start <= frame_start;
    end
  end

  nnds_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (s1_item),
    .cfg     (cfg),
    .emit    (emit),
    .result  (result)
  );

  // Output register: loaded by a word that yields a byte, cleared when drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (advance) begin
      byte_valid <= emit;
    end else if (byte_ready) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_reg <= result;
    end
  end

  assign bitmap_byte = out_reg.bitmap_byte;
  assign byte_index  = out_reg.byte_index;
  assign last        = out_reg.last;

  // The final byte of a frame always sits at the top index.
  `NNDS_ASSERT_NOW(a_last_index, byte_valid && last,
    byte_index == INDEX_W'(OUT_HEIGHT * BYTES_PER_ROW - 1), "last byte at wrong index")
  // A consumed word that packs a byte shows up at the output next cycle.
  `NNDS_ASSERT_NEXT(a_emit_shows, advance && emit, byte_valid, "packed byte lost")
  // A held stage-1 word keeps its pixel until it moves on.
  `NNDS_ASSERT_NEXT(a_s1_hold, s1_valid && !advance,
    s1_valid && $stable(s1_item), "stage-1 word changed while stalled")

endmodule

[tb/sv/nn_downscale_threshold_bitpack_tb.sv]
// Testbench for nn_downscale_threshold_bitpack: streams pixel words with random
// gaps and checks every packed bitmap byte against a built-in predictor.
// Depends on nnds_pkg and the nn_downscale_threshold_bitpack RTL.
`timescale 1ns / 100ps

module nn_downscale_threshold_bitpack_tb;
  import nnds_pkg::*;

  // Longest stretch without any accepted word: the receiver hold-off,
  // sender gaps and settle waits are far below this.
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 120;

  // Directed frame, threshold 100, row offset 0. Sampled columns are 0, 2, 5,
  // 7, 10, 12, 15, 17 -> 255, 0, 100, 99, 101, 254, 1, 100 -> byte 8'hAD.
  // Word 18 restarts the frame mid-line; the tail never completes a byte.
  localparam logic [0:23][7:0] DIRECTED_PIX = {
    8'd255, 8'd40, 8'd0, 8'd200, 8'd7, 8'd100, 8'd250, 8'd99, 8'd0, 8'd128,
    8'd101, 8'd3, 8'd254, 8'd99, 8'd255, 8'd1, 8'd255, 8'd100,
    8'd255, 8'd0, 8'd100, 8'd99, 8'd255, 8'd128};

  // Predictor of the scaler/binarizer/packer plus the store of bytes it owes.
  class bitmap_scoreboard;
    logic [THR_W-1:0]      threshold = THRESHOLD_RST;
    logic [ROFF_W-1:0]     row_offset = ROW_OFFSET_RST;
    logic [SRC_COL_W-1:0]  src_col;
    logic [SRC_ROW_W-1:0]  src_row;
    logic [COL_HALF_W-1:0] col_half;   // next wanted column, half-pixel units
    logic [ROW_HALF_W-1:0] row_half;   // next wanted row, half-pixel units
    logic [OUT_COL_W-1:0]  out_col;
    logic [OUT_ROW_W-1:0]  out_row;
    logic [7:0]            pack_bits;
    result_t               expected_bytes[$];
    int                    mismatches;

    function new();
      restart_frame();
    endfunction

    function void restart_frame();
      src_col   = '0;
      src_row   = '0;
      col_half  = '0;
      row_half  = ROW_HALF_W'(5 * int'(row_offset));
      out_col   = '0;
      out_row   = '0;
      pack_bits = '0;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, what);
    endfunction

    function void set_register(logic sel, logic [APB_DATA_W-1:0] value);
      if (sel == REG_THRESHOLD) threshold = value[THR_W-1:0];
      else row_offset = value[ROFF_W-1:0];
    endfunction

    function void check_readback(logic sel, logic [APB_DATA_W-1:0] got);
      if (sel == REG_THRESHOLD && got[THR_W-1:0] !== threshold)
        flag($sformatf("threshold read %0d, want %0d", got[THR_W-1:0], threshold));
      if (sel == REG_ROW_OFFSET && got[ROFF_W-1:0] !== row_offset)
        flag($sformatf("row_offset read %0d, want %0d", got[ROFF_W-1:0], row_offset));
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // One accepted pixel word; queues the byte it completes, if any.
    function void take_pixel(logic [PIX_W-1:0] pix, logic fs);
      logic    row_kept;
      int      fill;
      result_t r;
      if (fs) restart_frame();
      // frame done: everything is ignored until the next frame start
      if (int'(out_row) >= OUT_HEIGHT || int'(src_row) >= SRC_HEIGHT) return;
      row_kept = (src_row == (row_half >> 1));
      if (row_kept && int'(out_col) < OUT_WIDTH && src_col == (col_half >> 1)) begin
        pack_bits = {pack_bits[6:0], (pix >= threshold)};
        out_col   = out_col + 1'b1;
        col_half  = col_half + COL_HALF_W'(5);
        fill      = int'(out_col) % 8;
        if (fill == 0 || int'(out_col) == OUT_WIDTH) begin
          // short last byte of a row is left-aligned, low bits zero
          r.bitmap_byte = (fill != 0) ? pack_bits << (8 - fill) : pack_bits;
          r.byte_index  = INDEX_W'(int'(out_row) * BYTES_PER_ROW + (int'(out_col) - 1) / 8);
          r.last        = (int'(out_row) == OUT_HEIGHT - 1) && (int'(out_col) == OUT_WIDTH);
          expected_bytes.push_back(r);
          pack_bits = '0;
        end
      end
      src_col = src_col + 1'b1;
      if (int'(src_col) >= SRC_WIDTH) begin
        // end of source line: partial bits are dropped
        src_col   = '0;
        col_half  = '0;
        out_col   = '0;
        pack_bits = '0;
        if (row_kept) begin
          out_row  = out_row + 1'b1;
          row_half = row_half + ROW_HALF_W'(5);
        end
        src_row = src_row + 1'b1;
      end
    endfunction

    // One accepted byte word; compared with the oldest expectation.
    function void take_byte(result_t got);
      result_t want;
      if (expected_bytes.size() == 0) begin
        flag($sformatf("unexpected byte %02h index %0d last %0b",
                       got.bitmap_byte, got.byte_index, got.last));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.bitmap_byte !== want.bitmap_byte)
        flag($sformatf("index %0d: bitmap_byte %02h, want %02h",
                       want.byte_index, got.bitmap_byte, want.bitmap_byte));
      if (got.byte_index !== want.byte_index)
        flag($sformatf("byte_index %0d, want %0d", got.byte_index, want.byte_index));
      if (got.last !== want.last)
        flag($sformatf("index %0d: last %0b, want %0b", want.byte_index, got.last, want.last));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  pix_valid = 1'b0;
  logic                  pix_ready;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  frame_start = 1'b0;
  logic                  byte_valid;
  logic                  byte_ready = 1'b0;
  logic [7:0]            bitmap_byte;
  logic [INDEX_W-1:0]    byte_index;
  logic                  last;

  bitmap_scoreboard sb = new();

  // receiver control
  logic hold_armed = 1'b0;   // set once by the stimulus to request the long hold-off
  logic hold_done  = 1'b0;
  int   hold_left  = 0;
  int   rx_cycle   = 0;
  int   rx_mode    = 0;
  int   quiet_cycles = 0;

  nn_downscale_threshold_bitpack dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pixel      (pixel),
    .frame_start(frame_start),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .bitmap_byte(bitmap_byte),
    .byte_index (byte_index),
    .last       (last)
  );

  always #5 clk = ~clk;

  // Monitor: byte check first so a word accepted at the same edge cannot be
  // matched against a byte that was already in flight.
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && byte_ready) sb.take_byte(result_t'({bitmap_byte, byte_index, last}));
      if (pix_valid && pix_ready) sb.take_pixel(pixel, frame_start);
    end
  end

  // Receiver: stall pattern picked at random (always ready, coin flip,
  // mostly ready, periodic). One long hold-off on request fills the pipeline.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 512 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_armed && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      byte_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      byte_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       byte_ready <= 1'b1;
        1:       byte_ready <= 1'($urandom_range(0, 1));
        2:       byte_ready <= ($urandom_range(0, 99) < 85);
        default: byte_ready <= ((rx_cycle % 7) < 3);
      endcase
    end
  end

  // Watchdog: any accepted word or APB activity counts as progress.
  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (byte_valid && byte_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL nn_downscale_threshold_bitpack");
        $finish;
      end
    end
  end

  // Offer one pixel word and hold it until accepted.
  task automatic put_pixel(input logic [PIX_W-1:0] p, input logic fs);
    pix_valid   <= 1'b1;
    pixel       <= p;
    frame_start <= fs;
    do @(posedge clk); while (!pix_ready);
  endtask

  // Three in ten near the threshold, one in ten at the extremes, otherwise uniform.
  function automatic logic [PIX_W-1:0] pick_pixel(logic [THR_W-1:0] thr);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 30) v = int'(thr) + int'($urandom_range(0, 2)) - 1;
    else if (r < 35) v = 0;
    else if (r < 40) v = 255;
    else v = $urandom_range(0, 255);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  // Stream of pixel words; noise_pm is the per-mille chance of a stray frame
  // start. max_burst of zero means back to back, no gaps.
  task automatic stream(input int count, input logic start_first, input int noise_pm,
                        input int max_burst);
    int   i;
    int   burst;
    logic fs;
    burst = (max_burst != 0) ? $urandom_range(1, max_burst) : 0;
    for (i = 0; i < count; i++) begin
      fs = (i == 0) ? start_first : ($urandom_range(0, 999) < noise_pm);
      put_pixel(pick_pixel(sb.threshold), fs);
      if (max_burst != 0 && i != count - 1) begin
        burst--;
        if (burst == 0) begin
          pix_valid <= 1'b0;
          repeat (($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12))
            @(posedge clk);
          burst = $urandom_range(1, max_burst);
        end
      end
    end
  endtask

  // Short frames; about one in seven continues the current frame instead of
  // starting a new one, so a fresh row_offset waits for the next frame start.
  task automatic run_frames(input int items, input int max_burst);
    int sent;
    int len;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(40, 160);
      if (len > items - sent) len = items - sent;
      stream(len, ($urandom_range(0, 99) < 85), 2, max_burst);
      sent += len;
    end
  endtask

  // Sender waits for every owed byte, then lets the pipeline settle.
  task automatic drain(input int settle);
    pix_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // APB write then read-back of the same register, back to back.
  task automatic set_reg(input logic sel, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({sel, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(sel, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.check_readback(sel, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int i;
    int ph;
    int thr;
    int off;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // No frame start after reset, reset register values: the first kept row
    // lies far past these words, so nothing may come out.
    stream(SRC_WIDTH / 2, 1'b0, 0, 64);
    drain(4);

    set_reg(REG_THRESHOLD, 100);
    set_reg(REG_ROW_OFFSET, 0);
    for (i = 0; i < 24; i++) put_pixel(DIRECTED_PIX[i], (i == 0 || i == 18));
    drain(4);

    for (ph = 0; ph < 10; ph++) begin
      thr = $urandom_range(0, 255);
      off = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 32) : $urandom_range(0, 1);
      case (ph)
        0: begin thr = 0;   off = 0;  end
        1: begin thr = 255; off = 1;  end
        2: off = 0;
        3: off = 0;    // whole first output row, then the skipped second line
        4: off = 63;   // crop past the bottom: no byte comes out
        default: ;
      endcase
      set_reg(REG_THRESHOLD, thr);
      if (ph < 5 || $urandom_range(0, 1)) set_reg(REG_ROW_OFFSET, off);
      if (ph == 2) hold_armed <= 1'b1;
      if (ph == 2) stream(PHASE_ITEMS, 1'b1, 0, 24);
      else if (ph == 3) stream(SRC_WIDTH + 80, 1'b1, 0, 256);
      else if (ph == 4) stream(PHASE_ITEMS, 1'b1, 0, 256);
      else run_frames(PHASE_ITEMS, ph[0] ? 0 : 24);
      drain(4);
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS nn_downscale_threshold_bitpack");
    end else begin
      $display("FAIL nn_downscale_threshold_bitpack");
    end
    $finish;
  end

endmodule
